// File: design/tpem_pkg.sv
package tpem_pkg;

   // field widths
   localparam int PULSES_W = 12;
   localparam int TARIFF_W = 2;
   localparam int BUTTON_W = 2;
   localparam int POWER_W  = 23;
   localparam int RELAY_W  = 2;
   localparam int ENERGY_W = 32;
   localparam int LIMIT_W  = 32;

   // default sizing
   localparam int DEF_WINDOW  = 4;
   localparam int DEF_TARIFFS = 3;
   localparam int DEF_PERIODS = 5;

   // metering constants
   localparam int unsigned PULSES_PER_UNIT = 2974;
   localparam int unsigned WH_PER_UNIT     = 10;
   localparam int unsigned POWER_PER_PULSE = 1160;
   localparam int unsigned POWER_MAX       = 4750200;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'hFFFF_FFFF;

   // button codes
   localparam logic [BUTTON_W-1:0] BTN_NONE = 2'd0;
   localparam logic [BUTTON_W-1:0] BTN_ON   = 2'd1;
   localparam logic [BUTTON_W-1:0] BTN_OFF  = 2'd2;

   // relay command codes
   localparam logic [RELAY_W-1:0] RELAY_NONE   = 2'd0;
   localparam logic [RELAY_W-1:0] RELAY_ON     = 2'd1;
   localparam logic [RELAY_W-1:0] RELAY_OFF    = 2'd2;
   localparam logic [RELAY_W-1:0] RELAY_OFF_ON = 2'd3;

   typedef struct packed {
      logic [PULSES_W-1:0] pulses;
      logic [TARIFF_W-1:0] tariff;
      logic [BUTTON_W-1:0] button;
   } tpem_item_type;

   typedef struct packed {
      logic [ENERGY_W-1:0] total_energy;
      logic [ENERGY_W-1:0] tariff_energy;
   } tpem_energy_type;

   typedef struct packed {
      logic [POWER_W-1:0] power_now;
      logic               over_limit;
      logic [RELAY_W-1:0] relay_command;
   } tpem_power_type;

endpackage

// File: design/tpem_energy.sv
module tpem_energy
   import tpem_pkg::*;
#(
   parameter int TARIFFS = DEF_TARIFFS,
   parameter int PERIODS = DEF_PERIODS
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  tpem_item_type   item,
   output tpem_energy_type energy
);

   localparam int ROWS  = TARIFFS + 1;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int ACC_W = PULSES_W + 1;
   localparam int ADD_W = $clog2(2 * WH_PER_UNIT + 1);
   localparam logic [ACC_W-1:0] ONE_UNIT = ACC_W'(PULSES_PER_UNIT);
   localparam logic [ACC_W-1:0] TWO_UNIT = ACC_W'(2 * PULSES_PER_UNIT);

   logic [PULSES_W-1:0] remainder_ff;
   logic [PULSES_W-1:0] remainder_in;
   logic [ENERGY_W-1:0] energy_ff [ROWS][PERIODS];

   logic [ACC_W-1:0] acc;
   logic             ge_one;
   logic             ge_two;
   logic [ADD_W-1:0] add;
   logic             tariff_ok;
   logic [ROW_W-1:0] row;

   // at most two 10 Wh units per tick since remainder stays below one unit
   always_comb begin
      acc    = {1'b0, remainder_ff} + {1'b0, item.pulses};
      ge_two = (acc >= TWO_UNIT);
      ge_one = (acc >= ONE_UNIT);
      if (ge_two) begin
         remainder_in = PULSES_W'(acc - TWO_UNIT);
         add          = ADD_W'(2 * WH_PER_UNIT);
      end else if (ge_one) begin
         remainder_in = PULSES_W'(acc - ONE_UNIT);
         add          = ADD_W'(WH_PER_UNIT);
      end else begin
         remainder_in = PULSES_W'(acc);
         add          = '0;
      end
      tariff_ok = (item.tariff != '0) && (int'(item.tariff) <= TARIFFS);
      row       = ROW_W'(item.tariff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remainder_ff <= '0;
         for (int r = 0; r < ROWS; r++) begin
            for (int p = 0; p < PERIODS; p++) begin
               energy_ff[r][p] <= '0;
            end
         end
      end else if (step) begin
         remainder_ff <= remainder_in;
         for (int r = 0; r < ROWS; r++) begin
            for (int p = 0; p < PERIODS; p++) begin
               if (r == 0 || (tariff_ok && ROW_W'(r) == row)) begin
                  energy_ff[r][p] <= energy_ff[r][p] + ENERGY_W'(add);
               end
            end
         end
      end
   end

   // result shows the first period after this tick's update
   always_comb begin
      energy.total_energy = energy_ff[0][0] + ENERGY_W'(add);
      if (tariff_ok) begin
         energy.tariff_energy = energy_ff[row][0] + ENERGY_W'(add);
      end else begin
         energy.tariff_energy = '0;
      end
   end

endmodule

// File: design/tpem_power.sv
module tpem_power
   import tpem_pkg::*;
#(
   parameter int WINDOW = DEF_WINDOW
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  tpem_item_type      item,
   input  logic [LIMIT_W-1:0] power_limit,
   output tpem_power_type     power
);

   localparam int WIN_W  = $clog2(WINDOW);
   localparam int SUM_W  = PULSES_W + WIN_W;
   localparam int SHIFT  = SUM_W + WIN_W;
   localparam longint unsigned PWR_MULT =
      (longint'(POWER_PER_PULSE) * (64'd1 << SHIFT) + longint'(WINDOW) - 1) / WINDOW;
   localparam int PROD_W = SHIFT + POWER_W;

   logic [SUM_W-1:0]  win_sum;
   logic [PROD_W-1:0] prod;
   logic [POWER_W-1:0] power_now;
   logic               over;

   generate
      if (WINDOW > 1) begin : g_hist
         localparam int HIST = WINDOW - 1;
         logic [PULSES_W-1:0] hist_ff [HIST];
         logic [SUM_W-1:0]    hsum_ff;

         // running sum of the stored counts, one add and one subtract per tick
         always_ff @(posedge clock) begin
            if (reset) begin
               hsum_ff <= '0;
               for (int i = 0; i < HIST; i++) begin
                  hist_ff[i] <= '0;
               end
            end else if (step) begin
               hsum_ff <= hsum_ff - SUM_W'(hist_ff[0]) + SUM_W'(item.pulses);
               for (int i = 0; i < HIST - 1; i++) begin
                  hist_ff[i] <= hist_ff[i + 1];
               end
               hist_ff[HIST-1] <= item.pulses;
            end
         end

         assign win_sum = hsum_ff + SUM_W'(item.pulses);
      end else begin : g_nohist
         assign win_sum = SUM_W'(item.pulses);
      end
   endgenerate

   // sum * 1160 / WINDOW as one multiply by a scaled reciprocal, exact for all sums
   assign prod      = PROD_W'(win_sum) * PROD_W'(PWR_MULT);
   assign power_now = prod[SHIFT +: POWER_W];
   assign over      = (LIMIT_W'(power_now) > power_limit);

   always_comb begin
      power.power_now  = power_now;
      power.over_limit = over;
      power.relay_command = over ? RELAY_OFF : RELAY_NONE;
      case (item.button)
         BTN_ON:  power.relay_command = over ? RELAY_OFF_ON : RELAY_ON;
         BTN_OFF: power.relay_command = RELAY_OFF;
         default: ;
      endcase
   end

endmodule

// File: design/tariff_pulse_energy_meter_core.sv
// a beat accepted into the input stage moves on to the result stage, which drives rsp_
// throughput: one beat per cycle unless stalled; remainder, history and accumulators update on the step
// a stalled result holds the result stage, the input stage stalls once it is also full
// reset: synchronous, active high; clears remainder, interval history, all accumulators,
// both pipeline valids, and sets power_limit to all ones
// no clearing pass, the core is ready in the cycle after reset drops
module tariff_pulse_energy_meter_core
   import tpem_pkg::*;
#(
   parameter int WINDOW  = DEF_WINDOW,
   parameter int TARIFFS = DEF_TARIFFS,
   parameter int PERIODS = DEF_PERIODS
) (
   input  logic                clock,
   input  logic                reset,

   // input beat
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [PULSES_W-1:0] req_pulses,
   input  logic [TARIFF_W-1:0] req_tariff,
   input  logic [BUTTON_W-1:0] req_button,

   // result beat
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [POWER_W-1:0]  rsp_power_now,
   output logic                rsp_over_limit,
   output logic [RELAY_W-1:0]  rsp_relay_command,
   output logic [ENERGY_W-1:0] rsp_total_energy,
   output logic [ENERGY_W-1:0] rsp_tariff_energy,

   // power limit register
   input  logic                csr_write,
   input  logic [LIMIT_W-1:0]  csr_wdata
);

   // input register stage
   logic          in_vld_ff;
   logic          in_vld_in;
   tpem_item_type in_item_ff;

   // result register stage
   logic            out_vld_ff;
   logic            out_vld_in;
   tpem_energy_type out_energy_ff;
   tpem_power_type  out_power_ff;

   logic [LIMIT_W-1:0] limit_ff;

   tpem_energy_type energy;
   tpem_power_type  power;

   logic          advance;
   logic          step;
   tpem_item_type req_item;

   // result slot frees when empty or taken this cycle
   assign advance   = !out_vld_ff || !rsp_stall;
   // state updates exactly when the input stage hands its beat to the result stage
   assign step      = in_vld_ff && advance;
   // input stage takes a new beat whenever it is empty or draining
   assign req_stall = in_vld_ff && !advance;

   always_comb begin
      req_item.pulses = req_pulses;
      req_item.tariff = req_tariff;
      req_item.button = req_button;
      in_vld_in  = req_stall ? in_vld_ff : req_valid;
      out_vld_in = advance ? in_vld_ff : out_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         limit_ff   <= LIMIT_RESET;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (csr_write) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_item;
      end
      if (step) begin
         out_energy_ff <= energy;
         out_power_ff  <= power;
      end
   end

   // pulse remainder and per-tariff period accumulators
   tpem_energy #(
      .TARIFFS (TARIFFS),
      .PERIODS (PERIODS)
   ) u_energy (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item_ff),
      .energy (energy)
   );

   // windowed power, limit compare and relay request
   tpem_power #(
      .WINDOW (WINDOW)
   ) u_power (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .item        (in_item_ff),
      .power_limit (limit_ff),
      .power       (power)
   );

   assign rsp_valid         = out_vld_ff;
   assign rsp_power_now     = out_power_ff.power_now;
   assign rsp_over_limit    = out_power_ff.over_limit;
   assign rsp_relay_command = out_power_ff.relay_command;
   assign rsp_total_energy  = out_energy_ff.total_energy;
   assign rsp_tariff_energy = out_energy_ff.tariff_energy;

endmodule

// File: design/tpem_checker.sv
module tpem_checker
   import tpem_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic [PULSES_W-1:0] req_pulses,
   input logic [TARIFF_W-1:0] req_tariff,
   input logic [BUTTON_W-1:0] req_button,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [POWER_W-1:0]  rsp_power_now,
   input logic                rsp_over_limit,
   input logic [RELAY_W-1:0]  rsp_relay_command,
   input logic [ENERGY_W-1:0] rsp_total_energy,
   input logic [ENERGY_W-1:0] rsp_tariff_energy,
   input logic                csr_write,
   input logic [LIMIT_W-1:0]  csr_wdata
);

   // shadow of the limit as seen on the csr port
   logic [LIMIT_W-1:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_write) begin
         limit_ff <= csr_wdata;
      end
   end

   // nothing left over in the result stage after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat visible right after reset");

   // limit flag agrees with the power shown and the limit last written
   a_over_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_over_limit == (LIMIT_W'(rsp_power_now) > limit_ff)))
      else $error("over_limit disagrees with power and limit");

   // over limit always carries an off request
   a_over_relay: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_over_limit) |->
         (rsp_relay_command == RELAY_OFF || rsp_relay_command == RELAY_OFF_ON))
      else $error("over limit without relay off");

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_power_now) && $stable(rsp_total_energy)
          && $stable(rsp_tariff_energy) && $stable(rsp_relay_command)))
      else $error("stalled result beat changed");

   // stalled input beat stays on the port unchanged
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=>
         (req_valid && $stable(req_pulses) && $stable(req_tariff)
          && $stable(req_button)))
      else $error("stalled input beat changed");

endmodule

bind tariff_pulse_energy_meter_core tpem_checker u_tpem_checker (.*);

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
   import tpem_pkg::*;

   // tariff codes as the meter sees them, zero is not a tariff
   localparam logic [TARIFF_W-1:0] TARIFF_NONE  = 2'd0;
   localparam logic [TARIFF_W-1:0] TARIFF_PEAK  = 2'd1;
   localparam logic [TARIFF_W-1:0] TARIFF_HALF  = 2'd2;
   localparam logic [TARIFF_W-1:0] TARIFF_NIGHT = 2'd3;
   // button code the core has to ignore
   localparam logic [BUTTON_W-1:0] BTN_UNKNOWN  = 2'd3;

   localparam int RANDOM_PHASES    = 7;
   localparam int READINGS_PER_PHASE = 100;
   localparam int REPORT_LIMIT     = 10;

   // one result beat, flattened
   typedef struct packed {
      logic [POWER_W-1:0]  power_now;
      logic                over_limit;
      logic [RELAY_W-1:0]  relay_command;
      logic [ENERGY_W-1:0] total_energy;
      logic [ENERGY_W-1:0] tariff_energy;
   } reading_result_type;

   // one line of the directed table: optional limit write, the beat, optional typed answer
   typedef struct packed {
      bit                 load_limit;
      logic [LIMIT_W-1:0] limit;
      tpem_item_type      item;
      bit                 typed;
      reading_result_type want;
   } bench_row_type;

   localparam int DIRECTED_COUNT = 16;
   localparam bench_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // straight after reset: nothing stored, nothing measured
      '{1'b0, 32'd0, '{12'd0, TARIFF_PEAK, BTN_NONE},
        1'b1, '{23'd0, 1'b0, RELAY_NONE, 32'd0, 32'd0}},
      // full-scale second, one 10 Wh unit, switch-on request
      '{1'b0, 32'd0, '{12'd4095, TARIFF_NIGHT, BTN_ON},
        1'b1, '{23'd1187550, 1'b0, RELAY_ON, 32'd10, 32'd10}},
      // tariff out of range: only the sum row grows, tariff energy reads zero
      '{1'b0, 32'd0, '{12'd4095, TARIFF_NONE, BTN_OFF},
        1'b1, '{23'd2375100, 1'b0, RELAY_OFF, 32'd20, 32'd0}},
      // two units in one second, unknown button acts as none
      '{1'b0, 32'd0, '{12'd4095, TARIFF_HALF, BTN_UNKNOWN},
        1'b1, '{23'd3562650, 1'b0, RELAY_NONE, 32'd40, 32'd20}},
      // window full of maximum counts gives the top power
      '{1'b0, 32'd0, '{12'd4095, TARIFF_PEAK, BTN_NONE},
        1'b1, '{23'd4750200, 1'b0, RELAY_NONE, 32'd50, 32'd10}},
      // zero limit: any power at all trips the relay
      '{1'b1, 32'd0, '{12'd4095, TARIFF_PEAK, BTN_NONE},
        1'b1, '{23'd4750200, 1'b1, RELAY_OFF, 32'd60, 32'd20}},
      // over limit and switch-on gives off then on
      '{1'b0, 32'd0, '{12'd0, TARIFF_PEAK, BTN_ON}, 1'b0, '0},
      '{1'b0, 32'd0, '{12'd0, TARIFF_HALF, BTN_OFF}, 1'b0, '0},
      '{1'b0, 32'd0, '{12'd0, TARIFF_NIGHT, BTN_UNKNOWN}, 1'b0, '0},
      // window drained: zero power is not above a zero limit
      '{1'b0, 32'd0, '{12'd0, TARIFF_PEAK, BTN_NONE},
        1'b1, '{23'd0, 1'b0, RELAY_NONE, 32'd60, 32'd20}},
      '{1'b0, 32'd0, '{12'd0, TARIFF_PEAK, BTN_ON}, 1'b0, '0},
      // power exactly at the limit, then just above it
      '{1'b1, 32'd1160, '{12'd4, TARIFF_PEAK, BTN_NONE}, 1'b0, '0},
      '{1'b0, 32'd0, '{12'd1, TARIFF_HALF, BTN_NONE}, 1'b0, '0},
      // remainder carries over the unit boundary
      '{1'b0, 32'd0, '{12'd343, TARIFF_NIGHT, BTN_NONE}, 1'b0, '0},
      // limit back to all ones
      '{1'b1, LIMIT_RESET, '{12'd4095, TARIFF_NIGHT, BTN_ON}, 1'b0, '0},
      '{1'b0, 32'd0, '{12'd2000, TARIFF_NIGHT, BTN_NONE}, 1'b0, '0}
   };

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [PULSES_W-1:0] req_pulses;
   logic [TARIFF_W-1:0] req_tariff;
   logic [BUTTON_W-1:0] req_button;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [POWER_W-1:0]  rsp_power_now;
   logic                rsp_over_limit;
   logic [RELAY_W-1:0]  rsp_relay_command;
   logic [ENERGY_W-1:0] rsp_total_energy;
   logic [ENERGY_W-1:0] rsp_tariff_energy;
   logic                csr_write;
   logic [LIMIT_W-1:0]  csr_wdata;

   tariff_pulse_energy_meter_core uut (.*);

   // meter state mirrored on the bench side
   int unsigned         pulse_rem;
   logic [PULSES_W-1:0] recent_pulses [DEF_WINDOW-1];
   logic [ENERGY_W-1:0] energy_rows [DEF_TARIFFS+1][DEF_PERIODS];
   logic [LIMIT_W-1:0]  limit_shadow;

   reading_result_type readings_due [$];

   // idle knobs, flipped per phase so some stretches run back to back
   bit send_idle;
   bit recv_idle;

   int unsigned error_count;
   int unsigned sent_count;
   int unsigned checked_count;
   int unsigned limit_writes;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // runaway guard, far beyond the slowest legal run
   initial begin
      #3000000;
      $display("tb: failure");
      $finish;
   end

   // energy, windowed power and relay decision for one second of pulses
   function automatic reading_result_type next_reading(input tpem_item_type it);
      reading_result_type r;
      int unsigned        pool;
      logic [31:0]        gain;
      int unsigned        window_sum;
      bit                 known_tariff;
      known_tariff = (it.tariff >= 1) && (it.tariff <= DEF_TARIFFS);

      // every full batch of pulses is worth one energy unit
      pool = pulse_rem + it.pulses;
      gain = (pool / PULSES_PER_UNIT) * WH_PER_UNIT;
      pulse_rem = pool % PULSES_PER_UNIT;
      for (int p = 0; p < DEF_PERIODS; p++) begin
         energy_rows[0][p] += gain;
         if (known_tariff)
            energy_rows[it.tariff][p] += gain;
      end

      // moving window: this second plus the previous ones
      window_sum = it.pulses;
      for (int i = 0; i < DEF_WINDOW - 1; i++)
         window_sum += recent_pulses[i];
      for (int i = 0; i < DEF_WINDOW - 2; i++)
         recent_pulses[i] = recent_pulses[i+1];
      recent_pulses[DEF_WINDOW-2] = it.pulses;
      r.power_now = POWER_W'((window_sum * POWER_PER_PULSE) / DEF_WINDOW);

      // relay: over limit asks for off, buttons override
      r.over_limit = 32'(r.power_now) > limit_shadow;
      r.relay_command = r.over_limit ? RELAY_OFF : RELAY_NONE;
      if (it.button == BTN_ON)
         r.relay_command = r.over_limit ? RELAY_OFF_ON : RELAY_ON;
      else if (it.button == BTN_OFF)
         r.relay_command = RELAY_OFF;

      r.total_energy  = energy_rows[0][0];
      r.tariff_energy = known_tariff ? energy_rows[it.tariff][0] : '0;
      return r;
   endfunction

   // random second: free counts half the time, some steady load near a level, some extremes
   function automatic tpem_item_type random_reading(input int unsigned level);
      tpem_item_type it;
      int            near;
      int unsigned   sel;
      case ($urandom_range(0, 7))
         0: it.pulses = '0;
         1: it.pulses = '1;
         2, 3: begin
            near = int'(level) + int'($urandom_range(0, 64)) - 32;
            if (near < 0)
               near = 0;
            if (near > 4095)
               near = 4095;
            it.pulses = PULSES_W'(near);
         end
         default: it.pulses = PULSES_W'($urandom_range(0, 4095));
      endcase
      it.tariff = ($urandom_range(0, 9) == 0) ? TARIFF_NONE
                                               : TARIFF_W'($urandom_range(1, 3));
      sel = $urandom_range(0, 9);
      it.button = (sel < 6) ? BTN_NONE :
                  (sel < 8) ? BTN_ON :
                  (sel < 9) ? BTN_OFF : BTN_UNKNOWN;
      return it;
   endfunction

   // present one beat, after a random gap when send_idle is set; returns at the edge that takes it
   task automatic drive_reading(input tpem_item_type it, input bit typed,
                                input reading_result_type want);
      int unsigned        gap;
      reading_result_type predicted;
      gap = send_idle ? $urandom_range(0, 17) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_pulses <= it.pulses;
      req_tariff <= it.tariff;
      req_button <= it.button;
      do @(posedge clock); while (req_stall);
      // accepted at this edge
      predicted = next_reading(it);
      readings_due.push_back(typed ? want : predicted);
      sent_count++;
   endtask

   // quiet the input side, drain, then write the limit
   task automatic load_limit(input logic [LIMIT_W-1:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (readings_due.size() != 0) @(negedge clock);
      csr_write <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      limit_shadow = value;
      limit_writes++;
   endtask

   // result side: random hold-off per beat when recv_idle is set, then ready until one arrives
   initial begin
      int unsigned hold;
      rsp_stall = 1'b0;
      forever begin
         hold = recv_idle ? $urandom_range(0, 17) : 0;
         @(negedge clock);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   // result checker, oldest expectation first
   always @(posedge clock) begin
      reading_result_type got;
      reading_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got = '{rsp_power_now, rsp_over_limit, rsp_relay_command,
                 rsp_total_energy, rsp_tariff_energy};
         if (readings_due.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("tb: result beat with nothing pending at %0t", $realtime);
         end else begin
            want = readings_due.pop_front();
            if (got.power_now !== want.power_now
                || got.over_limit !== want.over_limit
                || got.relay_command !== want.relay_command
                || got.total_energy !== want.total_energy
                || got.tariff_energy !== want.tariff_energy) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("tb: result %0d (expected/actual) power %0d/%0d over %0b/%0b",
                           checked_count, want.power_now, got.power_now,
                           want.over_limit, got.over_limit);
                  $display("tb:    relay %0d/%0d total %0d/%0d tariff %0d/%0d",
                           want.relay_command, got.relay_command,
                           want.total_energy, got.total_energy,
                           want.tariff_energy, got.tariff_energy);
               end
            end
         end
         checked_count++;
      end
   end

   initial begin
      logic [LIMIT_W-1:0] phase_limit;
      int unsigned        level;
      tpem_item_type      it;

      req_valid  = 1'b0;
      req_pulses = '0;
      req_tariff = TARIFF_PEAK;
      req_button = BTN_NONE;
      csr_write  = 1'b0;
      csr_wdata  = '0;
      reset      = 1'b1;

      // bench copy of the meter in its reset state
      pulse_rem = 0;
      foreach (recent_pulses[i])
         recent_pulses[i] = '0;
      foreach (energy_rows[t, p])
         energy_rows[t][p] = '0;
      limit_shadow = LIMIT_RESET;
      send_idle = 1'b1;
      recv_idle = 1'b1;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (DIRECTED_ROWS[r]) begin
         if (DIRECTED_ROWS[r].load_limit)
            load_limit(DIRECTED_ROWS[r].limit);
         drive_reading(DIRECTED_ROWS[r].item, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
      end

      // random phases, each under its own limit and idle mix
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: phase_limit = $urandom_range(0, POWER_MAX);
            1: phase_limit = '0;
            2: phase_limit = POWER_MAX;
            3: phase_limit = LIMIT_RESET;
            4: phase_limit = $urandom();
            5: phase_limit = POWER_MAX - 1;
            default: phase_limit = $urandom_range(POWER_MAX / 4, 3 * POWER_MAX / 4);
         endcase
         load_limit(phase_limit);
         send_idle = (phase % 3) != 2;
         recv_idle = (phase % 2) == 0;
         level = $urandom_range(0, 4095);
         for (int n = 0; n < READINGS_PER_PHASE; n++) begin
            it = random_reading(level);
            drive_reading(it, 1'b0, '0);
         end
      end

      // drain, then idle on to catch stray beats
      @(negedge clock);
      req_valid <= 1'b0;
      while (readings_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("tb: %0d beats sent, %0d results checked, %0d limit settings",
               sent_count, checked_count, limit_writes);
      $display("tb: %0d failures (directed table plus %0d random phases)",
               error_count, RANDOM_PHASES);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
